/* sv/flash_thermometer_counter_assert.svh */
// Assertion macros shared by the flash thermometer counter RTL.
`ifndef FLASH_THERMOMETER_COUNTER_ASSERT_SVH
`define FLASH_THERMOMETER_COUNTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ftc_pkg.sv */
// Types and constants of the flash thermometer counter.
package ftc_pkg;

  // Sector and page sizes in bytes; both are powers of two.
  localparam int SECTOR_BYTES = 4096;
  localparam int PAGE_BYTES   = 256;

  localparam int COUNT_LIMIT  = (SECTOR_BYTES * 8 < 32768) ? SECTOR_BYTES * 8 : 32768;
  localparam int PAGE_COUNTS  = PAGE_BYTES * 8;
  localparam int PAGE_LOG2    = $clog2(PAGE_BYTES);
  localparam int PCNT_LOG2    = $clog2(PAGE_COUNTS);

  // Field widths.
  localparam int ADDR_W = 24;
  localparam int CNT_W  = 15;
  localparam int ZB_W   = 9;

  // Internal widths.
  localparam int POS_W  = $clog2(SECTOR_BYTES + 1);
  localparam int VAL_W  = POS_W + 3;
  localparam int NEXT_W = CNT_W + 1;
  localparam int BIDX_W = NEXT_W - 3;

  localparam logic ACTION_SCAN = 1'b0;
  localparam logic ACTION_INCR = 1'b1;

  typedef enum logic [1:0] {
    KIND_VALUE   = 2'd0,
    KIND_PROGRAM = 2'd1,
    KIND_ERASE   = 2'd2,
    KIND_REJECT  = 2'd3
  } kind_t;

  // Cleared low bits of a left-aligned mask; 8 marks an invalid byte.
  function automatic logic [3:0] mask_depth(input logic [7:0] b);
    logic [3:0] d;
    d = 4'd8;
    for (int k = 7; k >= 0; k--) begin
      if (b == 8'(8'hFF << k)) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

endpackage

/* sv/ftc_ifs.sv */
// Request and result channel interfaces of the flash thermometer counter.
interface ftc_req_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_data;
  logic       last_byte;

  modport source (output valid, action, byte_data, last_byte, input ready);
  modport sink   (input valid, action, byte_data, last_byte, output ready);
endinterface

interface ftc_rsp_if;
  logic                         valid;
  logic                         ready;
  ftc_pkg::kind_t               kind;
  logic [ftc_pkg::CNT_W-1:0]    count_value;
  logic [ftc_pkg::ADDR_W-1:0]   page_address;
  logic [ftc_pkg::ZB_W-1:0]     zero_bytes;
  logic [7:0]                   edge_byte;

  modport source (output valid, kind, count_value, page_address, zero_bytes, edge_byte,
                  input ready);
  modport sink   (input valid, kind, count_value, page_address, zero_bytes, edge_byte,
                  output ready);
endinterface

/* sv/flash_thermometer_counter.sv */
// Flash thermometer counter: sector scan decoder and increment page planner.
//
//   channel  direction  carries
//   req      in         action, byte_data, last_byte
//   rsp      out        kind, count_value, page_address, zero_bytes, edge_byte
//   cfg      in         sector_base write (cfg_we, cfg_wdata)
//
// Each request is decoded combinationally; a result appears in the result register
// on the cycle after its request is accepted, and a new request may follow
// every cycle. A held result only blocks new requests while rsp.ready is low.
// Reset clears the counter, the scan tracking and sector_base.
module flash_thermometer_counter (
  input  logic                       clk,
  input  logic                       rst,
  ftc_req_if.sink                    req,
  ftc_rsp_if.source                  rsp,
  input  logic                       cfg_we,
  input  logic [ftc_pkg::ADDR_W-1:0] cfg_wdata
);
  import ftc_pkg::*;

  `include "flash_thermometer_counter_assert.svh"

  logic [ADDR_W-1:0] sector_base;
  logic [CNT_W-1:0]  counter, counter_next;
  logic              counter_known, counter_known_next;
  logic [POS_W-1:0]  scan_position, scan_position_next;
  logic              found_nonzero, found_nonzero_next;
  logic [POS_W-1:0]  found_position, found_position_next;
  logic [7:0]        found_value, found_value_next;
  logic              scan_bad, scan_bad_next;

  logic              out_valid;
  kind_t             out_kind, res_kind;
  logic [CNT_W-1:0]  out_count;
  logic [ADDR_W-1:0] out_addr, res_addr;
  logic [ZB_W-1:0]   out_zeros, res_zeros;
  logic [7:0]        out_edge, res_edge;
  logic              res_valid;

  logic              accept;
  logic [3:0]        depth;
  logic [VAL_W-1:0]  value;
  logic [NEXT_W-1:0] incr;
  logic              at_boundary;
  logic [BIDX_W-1:0] byte_index;
  logic [BIDX_W-1:0] page_start;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign rsp.valid        = out_valid;
  assign rsp.kind         = out_kind;
  assign rsp.count_value  = out_count;
  assign rsp.page_address = out_addr;
  assign rsp.zero_bytes   = out_zeros;
  assign rsp.edge_byte    = out_edge;

  always_comb begin
    counter_next        = counter;
    counter_known_next  = counter_known;
    scan_position_next  = scan_position;
    found_nonzero_next  = found_nonzero;
    found_position_next = found_position;
    found_value_next    = found_value;
    scan_bad_next       = scan_bad;
    res_valid           = 1'b0;
    res_kind            = KIND_VALUE;
    res_addr            = '0;
    res_zeros           = '0;
    res_edge            = '0;
    depth               = '0;
    value               = '0;

    incr        = NEXT_W'(counter) + NEXT_W'(1);
    at_boundary = (incr[PCNT_LOG2-1:0] == '0);
    // At a page boundary the page just filled is written all zero.
    byte_index  = at_boundary ? BIDX_W'((incr - NEXT_W'(PAGE_COUNTS)) >> 3)
                              : BIDX_W'(incr >> 3);
    page_start  = (byte_index >> PAGE_LOG2) << PAGE_LOG2;

    if (req.action == ACTION_SCAN) begin
      if (!found_nonzero) begin
        if (req.byte_data != 8'h00) begin
          found_nonzero_next  = 1'b1;
          found_position_next = scan_position;
          found_value_next    = req.byte_data;
        end
      end else if (req.byte_data != 8'hFF) begin
        scan_bad_next = 1'b1;
      end
      if (scan_position < POS_W'(SECTOR_BYTES)) begin
        scan_position_next = scan_position + POS_W'(1);
      end
      depth = mask_depth(found_value_next);
      value = {found_position_next, 3'b000} + VAL_W'(depth);
      if (req.last_byte) begin
        res_valid          = 1'b1;
        counter_known_next = 1'b1;
        if (!found_nonzero_next || scan_bad_next || depth[3] ||
            value >= VAL_W'(COUNT_LIMIT)) begin
          counter_next = '0;
          res_kind     = KIND_ERASE;
          res_addr     = sector_base;
        end else begin
          counter_next = CNT_W'(value);
          res_kind     = KIND_VALUE;
        end
        scan_position_next  = '0;
        found_nonzero_next  = 1'b0;
        found_position_next = '0;
        found_value_next    = '0;
        scan_bad_next       = 1'b0;
      end
    end else begin
      res_valid = 1'b1;
      if (!counter_known) begin
        res_kind = KIND_REJECT;
      end else if (incr >= NEXT_W'(COUNT_LIMIT)) begin
        counter_next = '0;
        res_kind     = KIND_ERASE;
        res_addr     = sector_base;
      end else begin
        counter_next = CNT_W'(incr);
        res_kind     = KIND_PROGRAM;
        res_addr     = sector_base + ADDR_W'(page_start);
        if (at_boundary) begin
          res_zeros = ZB_W'(PAGE_BYTES);
        end else begin
          res_zeros = ZB_W'(byte_index[PAGE_LOG2-1:0]);
          res_edge  = 8'(8'hFF << incr[2:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_base    <= '0;
      counter        <= '0;
      counter_known  <= 1'b0;
      scan_position  <= '0;
      found_nonzero  <= 1'b0;
      found_position <= '0;
      found_value    <= '0;
      scan_bad       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        sector_base <= cfg_wdata;
      end
      if (accept) begin
        counter        <= counter_next;
        counter_known  <= counter_known_next;
        scan_position  <= scan_position_next;
        found_nonzero  <= found_nonzero_next;
        found_position <= found_position_next;
        found_value    <= found_value_next;
        scan_bad       <= scan_bad_next;
      end
      if (accept && res_valid) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_kind  <= res_kind;
      out_count <= counter_next;
      out_addr  <= res_addr;
      out_zeros <= res_zeros;
      out_edge  <= res_edge;
    end
  end

  `FTC_ASSERT_NEXT(a_reject_before_scan, accept && req.action == ACTION_INCR && !counter_known, rsp.valid && rsp.kind == KIND_REJECT, "increment before scan was not rejected")
  `FTC_ASSERT_NEXT(a_scan_end_known, accept && req.action == ACTION_SCAN && req.last_byte, counter_known && scan_position == '0 && rsp.valid, "scan end did not settle the counter")
  `FTC_ASSERT_NOW(a_erase_zero, rsp.valid && rsp.kind == KIND_ERASE, rsp.count_value == '0 && rsp.zero_bytes == '0, "erase result carries a nonzero count")
  `FTC_ASSERT_NOW(a_page_bounds, rsp.valid && rsp.kind == KIND_PROGRAM, rsp.zero_bytes <= ZB_W'(PAGE_BYTES), "page image zero run exceeds the page")
  `FTC_ASSERT_NOW(a_pos_bound, 1'b1, scan_position <= POS_W'(SECTOR_BYTES), "scan position past sector size")

endmodule
